@@ rtl/cau_pkg.sv @@
// Shared types, codes and helpers for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_t;

  localparam int unsigned NUM_W = 33;  // exact width of sums of two 16x16 products
  localparam int unsigned QUO_W = 17;  // quotient bits kept by the divider

  localparam logic signed [NUM_W-1:0] SAT_MAX = 33'sd32767;
  localparam logic signed [NUM_W-1:0] SAT_MIN = -33'sd32768;

  typedef struct packed {
    logic               ovf;
    logic signed [15:0] val;
  } sat_t;

  // Per-item side information that rides next to the divider.
  typedef struct packed {
    mode_t              mode;
    logic               dz;
    logic               neg_re;
    logic               neg_im;
    logic               big_re;   // quotient known to exceed the kept range
    logic               big_im;
    logic signed [15:0] pass_re;  // finished add/sub/mul result
    logic signed [15:0] pass_im;
    logic               pass_ovf;
  } side_t;

  function automatic sat_t sat16(input logic signed [NUM_W-1:0] v);
    sat_t s;
    s.ovf = 1'b0;
    if (v > SAT_MAX) begin
      s.ovf = 1'b1;
      s.val = 16'sh7FFF;
    end else if (v < SAT_MIN) begin
      s.ovf = 1'b1;
      s.val = -16'sh8000;
    end else begin
      s.val = v[15:0];
    end
    return s;
  endfunction

endpackage

@@ rtl/cau_front.sv @@
// Front end of the complex arithmetic unit: operand register, products,
// sums, add/sub/mul finish and divider setup. Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  mode_t                         in_mode,
  input  logic signed [15:0]            in_a_re,
  input  logic signed [15:0]            in_a_im,
  input  logic signed [15:0]            in_b_re,
  input  logic signed [15:0]            in_b_im,
  output logic                          out_valid,
  output side_t                         out_side,
  output logic        [NUM_W+FRAC_BITS-1:0] out_x_re,
  output logic        [NUM_W+FRAC_BITS-1:0] out_x_im,
  output logic        [31:0]            out_den
);

  localparam int unsigned XW = NUM_W + FRAC_BITS;
  localparam int unsigned CW = 32 + QUO_W + 1;
  localparam logic signed [NUM_W-1:0] RND = NUM_W'((64'd1 << FRAC_BITS) - 64'd1);

  // stage 1: operands
  logic               v1_r;
  mode_t              m1_r;
  logic signed [15:0] ar_r, ai_r, br_r, bi_r;

  // stage 2: products and add/sub
  logic               v2_r;
  mode_t              m2_r;
  logic signed [31:0] prr_r, pii_r, pri_r, pir_r, pbr_r, pbi_r;
  logic signed [16:0] sre_r, sim_r;

  // stage 3: sums
  logic               v3_r;
  mode_t              m3_r;
  logic signed [NUM_W-1:0] tre_r, tim_r;
  logic        [31:0] den3_r;

  // stage 4
  logic               v4_r;
  side_t              side_r;
  logic        [XW-1:0] xre_r, xim_r;
  logic        [31:0] den4_r;

  logic signed [NUM_W-1:0] shre, shim;
  logic        [NUM_W-1:0] abre, abim;
  logic        [XW-1:0]    xre_nxt, xim_nxt;
  logic        [CW-1:0]    lim;
  sat_t                    sre, sim;
  side_t                   side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    shre = tre_r;
    shim = tim_r;
    if (m3_r == MODE_MUL) begin
      shre = (tre_r + (tre_r[NUM_W-1] ? RND : NUM_W'(0))) >>> FRAC_BITS;
      shim = (tim_r + (tim_r[NUM_W-1] ? RND : NUM_W'(0))) >>> FRAC_BITS;
    end
    sre  = sat16(shre);
    sim  = sat16(shim);
    abre = tre_r[NUM_W-1] ? NUM_W'(-tre_r) : NUM_W'(tre_r);
    abim = tim_r[NUM_W-1] ? NUM_W'(-tim_r) : NUM_W'(tim_r);
    xre_nxt = XW'(abre) << FRAC_BITS;
    xim_nxt = XW'(abim) << FRAC_BITS;
    lim     = CW'(den3_r) << QUO_W;

    side_nxt.mode     = m3_r;
    side_nxt.dz       = (m3_r == MODE_DIV) && (den3_r == '0);
    side_nxt.neg_re   = tre_r[NUM_W-1];
    side_nxt.neg_im   = tim_r[NUM_W-1];
    side_nxt.big_re   = CW'(xre_nxt) >= lim;
    side_nxt.big_im   = CW'(xim_nxt) >= lim;
    side_nxt.pass_re  = sre.val;
    side_nxt.pass_im  = sim.val;
    side_nxt.pass_ovf = sre.ovf | sim.ovf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= in_mode;
      ar_r <= in_a_re;
      ai_r <= in_a_im;
      br_r <= in_b_re;
      bi_r <= in_b_im;

      m2_r  <= m1_r;
      prr_r <= ar_r * br_r;
      pii_r <= ai_r * bi_r;
      pri_r <= ar_r * bi_r;
      pir_r <= ai_r * br_r;
      pbr_r <= br_r * br_r;
      pbi_r <= bi_r * bi_r;
      sre_r <= (m1_r == MODE_SUB) ? 17'(ar_r) - 17'(br_r) : 17'(ar_r) + 17'(br_r);
      sim_r <= (m1_r == MODE_SUB) ? 17'(ai_r) - 17'(bi_r) : 17'(ai_r) + 17'(bi_r);

      m3_r   <= m2_r;
      den3_r <= 32'(pbr_r) + 32'(pbi_r);
      case (m2_r)
        MODE_MUL: begin
          tre_r <= NUM_W'(prr_r) - NUM_W'(pii_r);
          tim_r <= NUM_W'(pri_r) + NUM_W'(pir_r);
        end
        MODE_DIV: begin
          tre_r <= NUM_W'(prr_r) + NUM_W'(pii_r);
          tim_r <= NUM_W'(pir_r) - NUM_W'(pri_r);
        end
        default: begin
          tre_r <= NUM_W'(sre_r);
          tim_r <= NUM_W'(sim_r);
        end
      endcase

      side_r <= side_nxt;
      xre_r  <= xre_nxt;
      xim_r  <= xim_nxt;
      den4_r <= den3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_side  = side_r;
  assign out_x_re  = xre_r;
  assign out_x_im  = xim_r;
  assign out_den   = den4_r;

endmodule

@@ rtl/cau_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, most significant
// bit first. Caller guarantees x < den * 2^QUO_W. Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int unsigned XW = 41
) (
  input  logic              clk,
  input  logic              en,
  input  logic [XW-1:0]     x,
  input  logic [31:0]       den,
  output logic [QUO_W-1:0]  q
);

  localparam int unsigned RW = (XW > 32 + QUO_W) ? XW : 32 + QUO_W;

  logic [RW-1:0]    r_r [QUO_W];
  logic [31:0]      d_r [QUO_W];
  logic [QUO_W-1:0] q_r [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int unsigned K = QUO_W - 1 - g;
    logic [RW-1:0]    rin, sub;
    logic [31:0]      din;
    logic [QUO_W-1:0] qin;
    logic             geq;

    if (g == 0) begin : g_first
      assign rin = RW'(x);
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = r_r[g-1];
      assign din = d_r[g-1];
      assign qin = q_r[g-1];
    end

    assign sub = RW'(din) << K;
    assign geq = rin >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[g] <= geq ? rin - sub : rin;
        d_r[g] <= din;
        q_r[g] <= qin | (QUO_W'(geq) << K);
      end
    end
  end

  assign q = q_r[QUO_W-1];

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// Q-format operands. Top level; depends on cau_pkg, cau_front, cau_div.
//
// Usage:
//   Input beats arrive on in_tvalid/in_tready/in_tdata and carry the mode
//   and both complex operands. One result beat leaves on out_* per input
//   beat, in order, with both saturated result parts, an overflow flag and
//   a divide-by-zero flag (divide mode with b = 0 gives zero parts).
//   A beat passes 22 register stages from the accepting edge to out_tvalid:
//   4 front stages (operands, products, sums, finish/setup), 17 divider
//   stages of one quotient bit each and the output register, the first
//   loading at the accepting edge. Every mode takes the same path.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   17-stage divider is fully pipelined and two of them run side by side for
//   the real and imaginary parts.
//   When the receiver stalls, the whole pipeline freezes: in_tready drops
//   in the same cycle as out_tready while a result is held, and nothing is
//   lost or repeated. A bubble at the output never blocks intake.
//   Reset clears all valid bits; no result beat follows reset until a new
//   input beat is accepted.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode[1:0], a_re[17:2], a_im[33:18],
                                  // b_re[49:34], b_im[65:50], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // res_re[15:0], res_im[31:16],
                                  // overflow[32], divide_by_zero[33], zero pad
);

  localparam int unsigned XW = NUM_W + FRAC_BITS;

  logic            en;
  logic            f_valid;
  side_t           f_side;
  logic [XW-1:0]   f_x_re, f_x_im;
  logic [31:0]     f_den;
  logic [QUO_W-1:0] q_re, q_im;

  // side information and valid bits aligned with the divider stages
  logic  vd_r   [QUO_W];
  side_t side_r [QUO_W];

  logic               ov_r;
  logic signed [15:0] res_re_r, res_im_r;
  logic               ovf_r, dz_r;

  logic signed [15:0] res_re_nxt, res_im_nxt;
  logic               ovf_nxt, dz_nxt;
  side_t              s;

  // advance everything whenever the output slot is free or being taken
  assign en        = !ov_r || out_tready;
  assign in_tready = en;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_mode   (mode_t'(in_tdata[1:0])),
    .in_a_re   (in_tdata[17:2]),
    .in_a_im   (in_tdata[33:18]),
    .in_b_re   (in_tdata[49:34]),
    .in_b_im   (in_tdata[65:50]),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_x_re  (f_x_re),
    .out_x_im  (f_x_im),
    .out_den   (f_den)
  );

  cau_div #(.XW(XW)) u_div_re (
    .clk (clk),
    .en  (en),
    .x   (f_x_re),
    .den (f_den),
    .q   (q_re)
  );

  cau_div #(.XW(XW)) u_div_im (
    .clk (clk),
    .en  (en),
    .x   (f_x_im),
    .den (f_den),
    .q   (q_im)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= f_valid;
      for (int i = 1; i < QUO_W; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= f_side;
      for (int i = 1; i < QUO_W; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // finish: sign and saturate the quotients, give zero parts on divide by zero, or pass the early result
  always_comb begin
    s          = side_r[QUO_W-1];
    res_re_nxt = s.pass_re;
    res_im_nxt = s.pass_im;
    ovf_nxt    = s.pass_ovf;
    dz_nxt     = 1'b0;
    if (s.mode == MODE_DIV) begin
      if (s.dz) begin
        res_re_nxt = '0;
        res_im_nxt = '0;
        ovf_nxt    = 1'b0;
        dz_nxt     = 1'b1;
      end else begin
        ovf_nxt = 1'b0;
        if (s.neg_re) begin
          if (s.big_re || q_re > QUO_W'(32768)) begin
            res_re_nxt = -16'sh8000;
            ovf_nxt    = 1'b1;
          end else begin
            res_re_nxt = 16'(QUO_W'(0) - q_re);
          end
        end else begin
          if (s.big_re || q_re > QUO_W'(32767)) begin
            res_re_nxt = 16'sh7FFF;
            ovf_nxt    = 1'b1;
          end else begin
            res_re_nxt = q_re[15:0];
          end
        end
        if (s.neg_im) begin
          if (s.big_im || q_im > QUO_W'(32768)) begin
            res_im_nxt = -16'sh8000;
            ovf_nxt    = 1'b1;
          end else begin
            res_im_nxt = 16'(QUO_W'(0) - q_im);
          end
        end else begin
          if (s.big_im || q_im > QUO_W'(32767)) begin
            res_im_nxt = 16'sh7FFF;
            ovf_nxt    = 1'b1;
          end else begin
            res_im_nxt = q_im[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vd_r[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      ovf_r    <= ovf_nxt;
      dz_r     <= dz_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, dz_r, ovf_r, res_im_r, res_re_r};

endmodule
